// ===== hw/rtl/motion_presence_detector_unit_macros.svh =====
// Assertion macros shared by the checker of the motion and presence detector.
`ifndef MOTION_PRESENCE_DETECTOR_UNIT_MACROS_SVH
`define MOTION_PRESENCE_DETECTOR_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mpd_pkg.sv =====
// Shared constants, types and helper functions of the motion and presence detector.
`default_nettype none

package mpd_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int FRACTION_BITS = 16;

    localparam int DIM_W       = 11;
    localparam int PIX_W       = 8;
    localparam int THR_W       = 8;
    localparam int WGT_W       = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    localparam int WEIGHT_SHIFT = 16;
    localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(65536);

    localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT = DIM_W'(480);
    localparam logic [THR_W-1:0] RESET_MOTION_THR   = THR_W'(8);
    localparam logic [THR_W-1:0] RESET_PRESENCE_THR = THR_W'(8);
    localparam logic [WGT_W-1:0] RESET_MOTION_WGT   = WGT_W'(6554);
    localparam logic [WGT_W-1:0] RESET_PRESENCE_WGT = WGT_W'(7);

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int STORE_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int AVG_W  = PIX_W + FRACTION_BITS;
    localparam int PROD_W = AVG_W + WGT_W;
    localparam int STEP_W = AVG_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_MOTION_THR      = 3'd2,
        REG_PRESENCE_THR    = 3'd3,
        REG_MOTION_WEIGHT   = 3'd4,
        REG_PRESENCE_WEIGHT = 3'd5
    } mpd_reg_t;

    // One quarter-scale pixel on its way from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0]    scaled;
        logic [STORE_AW-1:0] idx;
        logic                primed;
        logic                frame_end;
    } mpd_item_t;

    // Effective frame size and the restart strobe of a size change.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             restart;
    } mpd_geom_t;

    // Thresholds and limited weights used by the averaging back end.
    typedef struct packed {
        logic [THR_W-1:0] motion_thr;
        logic [THR_W-1:0] presence_thr;
        logic [WGT_W-1:0] motion_weight;
        logic [WGT_W-1:0] presence_weight;
    } mpd_update_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(2)) begin
            r = DIM_W'(2);
        end else if (32'(v) > maxv) begin
            r = DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [WGT_W-1:0] sat_weight(input logic [WGT_W-1:0] w);
        return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/motion_presence_detector_unit.sv =====
// Top level of the motion and presence detector: configuration registers and block wiring.
//
// Usage. Full-resolution luma pixels enter in raster order on the input channel
// (in_valid, in_ready, luma_pixel); one pixel is taken per cycle. Each 2x2 block
// becomes one quarter-scale pixel, which leaves on the output channel (out_valid,
// out_ready, scaled_luma, motion_flag, presence_flag, frame_end) together with its
// flags; frame_end marks the last block of a frame. A trailing odd column or line
// is consumed without a result, so at most one item leaves for every four pixels.
// The item for a block becomes valid after the pixel that completes the block is
// accepted and the item has passed the front-to-back queue, the average store read,
// the compare, and the weight multiply and update.
// Throughput is one pixel per cycle as long as the receiver keeps taking items.
// The averages live in two single-port-write stores of 2^18 entries; a block whose
// entry is still being updated waits, which can only happen in frames of three
// blocks or fewer.
// When the receiver stalls, the back end holds still, the four-entry queue fills
// and then in_ready drops. Reset returns the registers to their defaults and
// starts an unprimed frame: its items load both averages and carry no flags. A
// write that changes the effective frame size also starts one; write registers only
// while the block is idle.
`default_nettype none

module motion_presence_detector_unit import mpd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PIX_W-1:0]       luma_pixel,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIX_W-1:0]       scaled_luma,
    output logic                   motion_flag,
    output logic                   presence_flag,
    output logic                   frame_end,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [THR_W-1:0] mthr_reg, mthr_next;
    logic [THR_W-1:0] pthr_reg, pthr_next;
    logic [WGT_W-1:0] mwgt_reg, mwgt_next;
    logic [WGT_W-1:0] pwgt_reg, pwgt_next;
    logic             restart;

    mpd_geom_t   geom;
    mpd_update_t upd;
    logic        push, queue_full, head_valid, pop;
    mpd_item_t   push_item, head;

    // Register writes. A size write restarts the frame only when the clamped
    // size really changes, so rewriting the same size keeps the averages primed.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        mthr_next   = mthr_reg;
        pthr_next   = pthr_reg;
        mwgt_next   = mwgt_reg;
        pwgt_next   = pwgt_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            case (mpd_reg_t'(cfg_index))
                REG_FRAME_WIDTH:
                begin
                    width_next = cfg_data[DIM_W-1:0];
                    restart    = clamp_dim(width_next, MAX_WIDTH)
                              != clamp_dim(width_reg, MAX_WIDTH);
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = cfg_data[DIM_W-1:0];
                    restart     = clamp_dim(height_next, MAX_HEIGHT)
                               != clamp_dim(height_reg, MAX_HEIGHT);
                end
                REG_MOTION_THR:      mthr_next = cfg_data[THR_W-1:0];
                REG_PRESENCE_THR:    pthr_next = cfg_data[THR_W-1:0];
                REG_MOTION_WEIGHT:   mwgt_next = cfg_data[WGT_W-1:0];
                REG_PRESENCE_WEIGHT: pwgt_next = cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_FRAME_WIDTH;
            height_reg <= RESET_FRAME_HEIGHT;
            mthr_reg   <= RESET_MOTION_THR;
            pthr_reg   <= RESET_PRESENCE_THR;
            mwgt_reg   <= RESET_MOTION_WGT;
            pwgt_reg   <= RESET_PRESENCE_WGT;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mthr_reg   <= mthr_next;
            pthr_reg   <= pthr_next;
            mwgt_reg   <= mwgt_next;
            pwgt_reg   <= pwgt_next;
        end
    end

    // Effective settings: size clamped to the supported range, weights to one.
    assign geom.width          = clamp_dim(width_reg, MAX_WIDTH);
    assign geom.height         = clamp_dim(height_reg, MAX_HEIGHT);
    assign geom.restart        = restart;
    assign upd.motion_thr      = mthr_reg;
    assign upd.presence_thr    = pthr_reg;
    assign upd.motion_weight   = sat_weight(mwgt_reg);
    assign upd.presence_weight = sat_weight(pwgt_reg);

    mpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .pix_valid  (in_valid),
        .pix_ready  (in_ready),
        .pix        (luma_pixel),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    mpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (head_valid),
        .item          (head),
        .item_pop      (pop),
        .upd           (upd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .scaled_luma   (scaled_luma),
        .motion_flag   (motion_flag),
        .presence_flag (presence_flag),
        .frame_end     (frame_end)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mpd_front.sv =====
// Front end: raster counters, half-line buffer and 2x2 block averaging.
`default_nettype none

module mpd_front import mpd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  mpd_geom_t        geom,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  logic [PIX_W-1:0] pix,
    output logic             push,
    output mpd_item_t        push_item,
    input  logic             queue_full
);

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [PIX_W-1:0]    left_reg, left_next;
    logic                primed_reg, primed_next;
    logic [STORE_AW-1:0] qidx_reg, qidx_next;

    logic [PIX_W:0]      line_mem [LINE_DEPTH];
    logic [PIX_W:0]      line_rd_reg;

    logic                accept;
    logic [LINE_AW-1:0]  line_addr;
    logic                col_last, row_last;
    logic [PIX_W:0]      pair;
    logic [PIX_W+1:0]    block_sum;
    logic                last_block;

    assign pix_ready = !queue_full;
    assign accept    = pix_valid && pix_ready;
    assign line_addr = LINE_AW'(col_reg >> 1);

    assign col_last = (32'(col_reg) == 32'(geom.width) - 32'd1);
    assign row_last = (32'(row_reg) == 32'(geom.height) - 32'd1);

    assign pair      = {1'b0, left_reg} + {1'b0, pix};
    assign block_sum = {1'b0, line_rd_reg} + {1'b0, pair};

    // The bottom-right block of the even-cropped frame.
    assign last_block = (32'(col_reg >> 1) == 32'(geom.width >> 1) - 32'd1)
                     && (32'(row_reg >> 1) == 32'(geom.height >> 1) - 32'd1);

    assign push                = accept && col_reg[0] && row_reg[0];
    assign push_item.scaled    = block_sum[PIX_W+1:2];
    assign push_item.idx       = qidx_reg;
    assign push_item.primed    = primed_reg;
    assign push_item.frame_end = last_block;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        primed_next = primed_reg;
        qidx_next   = qidx_reg;
        if (geom.restart)
        begin
            col_next    = '0;
            row_next    = '0;
            left_next   = '0;
            primed_next = 1'b0;
            qidx_next   = '0;
        end
        else if (accept)
        begin
            if (!col_reg[0])
            begin
                left_next = pix;
            end
            if (push)
            begin
                qidx_next = qidx_reg + STORE_AW'(1);
            end
            if (col_last)
            begin
                col_next = '0;
                if (row_last)
                begin
                    row_next    = '0;
                    primed_next = 1'b1;
                    qidx_next   = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            primed_reg <= 1'b0;
            qidx_reg   <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            primed_reg <= primed_next;
            qidx_reg   <= qidx_next;
        end
    end

    // Even lines store pair sums; the even column of an odd line fetches the
    // pair sum above, which is held until its odd partner arrives.
    always_ff @(posedge clk)
    begin
        if (accept && !col_reg[0])
        begin
            line_rd_reg <= line_mem[line_addr];
        end
        if (accept && col_reg[0] && !row_reg[0])
        begin
            line_mem[line_addr] <= pair;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mpd_queue.sv =====
// Short item queue between the front end and the averaging back end.
`default_nettype none

module mpd_queue import mpd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  mpd_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output mpd_item_t head
);

    mpd_item_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                               : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                               : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mpd_back.sv =====
// Back end: per-pixel running averages, threshold flags and the output register.
`default_nettype none

module mpd_back import mpd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  mpd_item_t        item,
    output logic             item_pop,
    input  mpd_update_t      upd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] scaled_luma,
    output logic             motion_flag,
    output logic             presence_flag,
    output logic             frame_end
);

    localparam int SUM_W = AVG_W + 2;
    localparam logic [AVG_W-1:0] AVG_TOP = {AVG_W{1'b1}};

    typedef struct packed {
        logic             ge;
        logic [AVG_W-1:0] avg;
        logic [AVG_W-1:0] mag;
    } mpd_diff_t;

    typedef struct packed {
        logic              ge;
        logic [AVG_W-1:0]  avg;
        logic [STEP_W-1:0] step;
    } mpd_move_t;

    function automatic mpd_diff_t diff_of(input logic [AVG_W-1:0] avg,
                                          input logic [AVG_W-1:0] pfx);
        mpd_diff_t d;
        d.ge  = (pfx >= avg);
        d.avg = avg;
        d.mag = d.ge ? (pfx - avg) : (avg - pfx);
        return d;
    endfunction

    function automatic logic [AVG_W-1:0] move_avg(input mpd_move_t m);
        logic [SUM_W-1:0] sum;
        logic [AVG_W-1:0] r;
        sum = SUM_W'(m.avg) + SUM_W'(m.step);
        if (m.ge)
        begin
            r = (sum > SUM_W'(AVG_TOP)) ? AVG_TOP : sum[AVG_W-1:0];
        end
        else
        begin
            r = (SUM_W'(m.step) > SUM_W'(m.avg)) ? '0
                                                  : AVG_W'(SUM_W'(m.avg) - SUM_W'(m.step));
        end
        return r;
    endfunction

    logic [AVG_W-1:0] recent_mem [STORE_DEPTH];
    logic [AVG_W-1:0] backgr_mem [STORE_DEPTH];
    logic [AVG_W-1:0] rd_recent_reg, rd_backgr_reg;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    mpd_item_t        s1_item_reg, s2_item_reg, s3_item_reg;
    mpd_diff_t        s2_rec_reg, s2_bg_reg;
    mpd_move_t        s3_rec_reg, s3_bg_reg;
    logic             s2_mflag_reg, s2_pflag_reg, s3_mflag_reg, s3_pflag_reg;
    logic [PIX_W-1:0] out_scaled_reg;
    logic             out_mflag_reg, out_pflag_reg, out_end_reg;

    logic             advance, hazard, wr_en;
    logic [AVG_W-1:0] s1_pfx, s3_pfx, new_recent, new_backgr;
    mpd_diff_t        s1_rec, s1_bg;
    logic             s1_mflag, s1_pflag;
    logic [PROD_W-1:0] rec_prod, bg_prod;
    mpd_move_t        s2_rec_move, s2_bg_move;

    // Whole pipeline moves together whenever the output register is free.
    assign advance = !out_valid_reg || out_ready;

    // An entry still being updated further down may not be read again.
    assign hazard = (s1_valid_reg && s1_item_reg.idx == item.idx)
                 || (s2_valid_reg && s2_item_reg.idx == item.idx)
                 || (s3_valid_reg && s3_item_reg.idx == item.idx);
    assign item_pop = advance && item_valid && !hazard;
    assign wr_en    = advance && s3_valid_reg;

    assign s1_pfx   = {s1_item_reg.scaled, {FRACTION_BITS{1'b0}}};
    assign s1_rec   = diff_of(rd_recent_reg, s1_pfx);
    assign s1_bg    = diff_of(rd_backgr_reg, s1_pfx);
    assign s1_mflag = s1_item_reg.primed
                   && (s1_rec.mag > {upd.motion_thr, {FRACTION_BITS{1'b0}}});
    assign s1_pflag = s1_item_reg.primed
                   && (s1_bg.mag > {upd.presence_thr, {FRACTION_BITS{1'b0}}});

    assign rec_prod = PROD_W'(s2_rec_reg.mag) * PROD_W'(upd.motion_weight);
    assign bg_prod  = PROD_W'(s2_bg_reg.mag) * PROD_W'(upd.presence_weight);

    assign s2_rec_move.ge   = s2_rec_reg.ge;
    assign s2_rec_move.avg  = s2_rec_reg.avg;
    assign s2_rec_move.step = STEP_W'(rec_prod >> WEIGHT_SHIFT);
    assign s2_bg_move.ge    = s2_bg_reg.ge;
    assign s2_bg_move.avg   = s2_bg_reg.avg;
    assign s2_bg_move.step  = STEP_W'(bg_prod >> WEIGHT_SHIFT);

    // Unprimed pixels load both averages with the pixel itself.
    assign s3_pfx     = {s3_item_reg.scaled, {FRACTION_BITS{1'b0}}};
    assign new_recent = s3_item_reg.primed ? move_avg(s3_rec_reg) : s3_pfx;
    assign new_backgr = s3_item_reg.primed ? move_avg(s3_bg_reg) : s3_pfx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= item_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg  <= item;
            s2_item_reg  <= s1_item_reg;
            s2_rec_reg   <= s1_rec;
            s2_bg_reg    <= s1_bg;
            s2_mflag_reg <= s1_mflag;
            s2_pflag_reg <= s1_pflag;
            s3_item_reg  <= s2_item_reg;
            s3_rec_reg   <= s2_rec_move;
            s3_bg_reg    <= s2_bg_move;
            s3_mflag_reg <= s2_mflag_reg;
            s3_pflag_reg <= s2_pflag_reg;
        end
        if (wr_en)
        begin
            out_scaled_reg <= s3_item_reg.scaled;
            out_mflag_reg  <= s3_mflag_reg;
            out_pflag_reg  <= s3_pflag_reg;
            out_end_reg    <= s3_item_reg.frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            rd_recent_reg <= recent_mem[item.idx];
            rd_backgr_reg <= backgr_mem[item.idx];
        end
        if (wr_en)
        begin
            recent_mem[s3_item_reg.idx] <= new_recent;
            backgr_mem[s3_item_reg.idx] <= new_backgr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign scaled_luma   = out_scaled_reg;
    assign motion_flag   = out_mflag_reg;
    assign presence_flag = out_pflag_reg;
    assign frame_end     = out_end_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mpd_checker.sv =====
// Port-level checker of the motion and presence detector and its bind.
`default_nettype none
`include "motion_presence_detector_unit_macros.svh"

module mpd_checker import mpd_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [PIX_W-1:0] scaled_luma,
    input wire logic             motion_flag,
    input wire logic             presence_flag,
    input wire logic             frame_end
);

    logic seen_end_reg;

    // Set once the first frame after reset has been delivered completely.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_end_reg <= 1'b0;
        end
        else if (out_valid && out_ready && frame_end)
        begin
            seen_end_reg <= 1'b1;
        end
    end

    `MPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled item was dropped")
    `MPD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(scaled_luma), "stalled item changed")
    `MPD_ASSERT_NOW(a_empty_after_reset, $past(!rst_n), !out_valid, "item appeared right after reset")
    `MPD_ASSERT_NOW(a_first_frame_quiet, out_valid && !seen_end_reg, !motion_flag && !presence_flag, "flag raised in unprimed frame")

endmodule

bind motion_presence_detector_unit mpd_checker u_checker (.*);

`default_nettype wire
